// ===== src/ccd_pkg.sv =====
// Shared types, codes and constants of the character-cell draw engine.
// No dependencies; every other file of the block refers to this package.
package ccd_pkg;

   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 32;

   localparam int CMD_W  = 3;
   localparam int CHAR_W = 8;
   localparam int POS_W  = 8;    // clipped column or row index
   localparam int DIM_W  = 9;    // used width or height, up to 256
   localparam int CRD_W  = 10;   // signed coordinate with room for corner sums
   localparam int CSR_W  = 7;
   localparam int CSR_IDX_W = 1;

   localparam int QUEUE_DEPTH     = 2;
   localparam int MAX_OUTSTANDING = QUEUE_DEPTH + 2;

   localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

   localparam logic [6:0] SURFACE_WIDTH_RST  = 7'd64;
   localparam logic [5:0] SURFACE_HEIGHT_RST = 6'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_HEIGHT = 1'b1;

   localparam logic [CMD_W-1:0] CMD_SET      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_GET      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RECT     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_BORDER   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REPLACE  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FILL_ALL = 3'd5;

   typedef enum logic [2:0] {
      KIND_WRITE,
      KIND_BORDER,
      KIND_REPLACE,
      KIND_GET,
      KIND_NOP
   } kind_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_WRITE,
      ACT_COND,
      ACT_READ
   } act_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BASE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   // One classified command, clipped to the surface.
   typedef struct packed {
      kind_type                kind;
      logic                    empty;
      logic [POS_W-1:0]        c0;
      logic [POS_W-1:0]        c1;
      logic [POS_W-1:0]        r0;
      logic [POS_W-1:0]        r1;
      logic signed [CRD_W-1:0] edge_l;
      logic signed [CRD_W-1:0] edge_r;
      logic signed [CRD_W-1:0] edge_t;
      logic signed [CRD_W-1:0] edge_b;
      logic [CHAR_W-1:0]       char_a;
      logic [CHAR_W-1:0]       char_b;
      logic [DIM_W-1:0]        stride;
   } cmd_entry_type;

endpackage

// ===== src/ccd_front.sv =====
// Front end: accepts request items, clips them to the surface and classifies them.
// Depends on ccd_pkg.
module ccd_front #(
   parameter int MAX_WIDTH  = ccd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ccd_pkg::MAX_HEIGHT_DEF
) (
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [47:0]               req_tdata,
   input  logic [ccd_pkg::CMD_W-1:0] req_tuser,
   input  logic [6:0]                surface_width,
   input  logic [5:0]                surface_height,
   input  logic                      queue_full,
   input  logic                      clearing,
   output logic                      push,
   output ccd_pkg::cmd_entry_type    push_entry
);

   localparam int CW = ccd_pkg::CRD_W;
   localparam int DW = ccd_pkg::DIM_W;

   logic [7:0]           pos_x;
   logic [7:0]           pos_y;
   logic [6:0]           rect_width;
   logic [6:0]           rect_height;
   logic [7:0]           char_a;
   logic [7:0]           char_b;
   logic [DW-1:0]        used_w;
   logic [DW-1:0]        used_h;
   logic signed [CW-1:0] wm1;
   logic signed [CW-1:0] hm1;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic signed [CW-1:0] wv;
   logic signed [CW-1:0] hv;
   logic signed [CW-1:0] xl;
   logic signed [CW-1:0] xh;
   logic signed [CW-1:0] yl;
   logic signed [CW-1:0] yh;
   logic signed [CW-1:0] cl_x0;
   logic signed [CW-1:0] cl_x1;
   logic signed [CW-1:0] cl_y0;
   logic signed [CW-1:0] cl_y1;
   ccd_pkg::kind_type    kind;

   assign pos_x       = req_tdata[7:0];
   assign pos_y       = req_tdata[15:8];
   assign rect_width  = req_tdata[22:16];
   assign rect_height = req_tdata[29:23];
   assign char_a      = req_tdata[37:30];
   assign char_b      = req_tdata[45:38];

   assign used_w = ({2'b00, surface_width} < DW'(MAX_WIDTH)) ?
                   {2'b00, surface_width} : DW'(MAX_WIDTH);
   assign used_h = ({3'b000, surface_height} < DW'(MAX_HEIGHT)) ?
                   {3'b000, surface_height} : DW'(MAX_HEIGHT);

   // An empty surface makes the last index -1, which empties every clip window.
   assign wm1 = $signed({1'b0, used_w}) - CW'(1);
   assign hm1 = $signed({1'b0, used_h}) - CW'(1);

   assign xs = $signed({{(CW-8){pos_x[7]}}, pos_x});
   assign ys = $signed({{(CW-8){pos_y[7]}}, pos_y});
   assign wv = $signed({{(CW-7){1'b0}}, rect_width});
   assign hv = $signed({{(CW-7){1'b0}}, rect_height});

   always_comb begin
      kind = ccd_pkg::KIND_NOP;
      xl   = xs;
      xh   = xs;
      yl   = ys;
      yh   = ys;
      case (req_tuser)
         ccd_pkg::CMD_SET: begin
            kind = ccd_pkg::KIND_WRITE;
         end
         ccd_pkg::CMD_GET: begin
            kind = ccd_pkg::KIND_GET;
         end
         ccd_pkg::CMD_RECT: begin
            kind = ccd_pkg::KIND_WRITE;
            xh   = xs + wv - CW'(1);
            yh   = ys + hv - CW'(1);
         end
         ccd_pkg::CMD_BORDER: begin
            kind = ccd_pkg::KIND_BORDER;
            xh   = xs + wv;
            yh   = ys + hv;
         end
         ccd_pkg::CMD_REPLACE: begin
            kind = ccd_pkg::KIND_REPLACE;
            xl   = '0;
            xh   = wm1;
            yl   = '0;
            yh   = hm1;
         end
         ccd_pkg::CMD_FILL_ALL: begin
            kind = ccd_pkg::KIND_WRITE;
            xl   = '0;
            xh   = wm1;
            yl   = '0;
            yh   = hm1;
         end
         default: begin
            kind = ccd_pkg::KIND_NOP;
         end
      endcase
   end

   assign cl_x0 = (xl < 0)   ? '0  : xl;
   assign cl_x1 = (xh > wm1) ? wm1 : xh;
   assign cl_y0 = (yl < 0)   ? '0  : yl;
   assign cl_y1 = (yh > hm1) ? hm1 : yh;

   always_comb begin
      push_entry.kind   = kind;
      push_entry.empty  = (kind == ccd_pkg::KIND_NOP) || (cl_x1 < cl_x0) || (cl_y1 < cl_y0);
      push_entry.c0     = cl_x0[ccd_pkg::POS_W-1:0];
      push_entry.c1     = cl_x1[ccd_pkg::POS_W-1:0];
      push_entry.r0     = cl_y0[ccd_pkg::POS_W-1:0];
      push_entry.r1     = cl_y1[ccd_pkg::POS_W-1:0];
      push_entry.edge_l = xl;
      push_entry.edge_r = xh;
      push_entry.edge_t = yl;
      push_entry.edge_b = yh;
      push_entry.char_a = char_a;
      push_entry.char_b = char_b;
      push_entry.stride = used_w;
   end

   assign req_tready = !queue_full && !clearing;
   assign push       = req_tvalid && req_tready;

endmodule

// ===== src/ccd_queue.sv =====
// Short command queue between the front end and the drawing back end.
// Depends on ccd_pkg for the entry type and depth.
module ccd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ccd_pkg::cmd_entry_type push_entry,
   output logic                   full,
   output logic                   not_empty,
   output ccd_pkg::cmd_entry_type head,
   input  logic                   pop
);

   localparam int DEPTH = ccd_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   ccd_pkg::cmd_entry_type entry_ff [DEPTH];
   logic [PW-1:0]          wr_ptr_ff;
   logic [PW-1:0]          wr_ptr_in;
   logic [PW-1:0]          rd_ptr_ff;
   logic [PW-1:0]          rd_ptr_in;
   logic [PW:0]            count_ff;
   logic [PW:0]            count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full      = (count_ff == (PW+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/ccd_back.sv =====
// Back end: cell store, clearing pass, scan sequencer and the result register.
// Depends on ccd_pkg for the entry type, state and action codes.
module ccd_back #(
   parameter int MAX_WIDTH  = ccd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ccd_pkg::MAX_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  ccd_pkg::cmd_entry_type q_head,
   output logic                   q_pop,
   output logic                   clearing,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic [0:0]             rsp_tuser
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = ccd_pkg::POS_W;
   localparam int CW    = ccd_pkg::CRD_W;
   localparam int DW    = ccd_pkg::DIM_W;

   logic [7:0]             mem [DEPTH];
   logic [7:0]             rdata_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [7:0]             mem_wdata;
   logic [AW-1:0]          scan_addr;

   ccd_pkg::state_type     state_ff;
   ccd_pkg::state_type     state_in;
   ccd_pkg::cmd_entry_type cur_ff;
   ccd_pkg::cmd_entry_type cur_in;
   logic [PW-1:0]          col_ff;
   logic [PW-1:0]          col_in;
   logic [PW-1:0]          row_ff;
   logic [PW-1:0]          row_in;
   logic [AW-1:0]          base_ff;
   logic [AW-1:0]          base_in;
   logic [AW-1:0]          clr_addr_ff;
   logic [AW-1:0]          clr_addr_in;
   ccd_pkg::act_type       s2_act_ff;
   ccd_pkg::act_type       s2_act_in;
   logic [AW-1:0]          s2_addr_ff;
   logic [AW-1:0]          s2_addr_in;
   logic [7:0]             s2_code_ff;
   logic [7:0]             s2_code_in;
   logic [7:0]             get_char_ff;
   logic [7:0]             get_char_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [7:0]             rsp_char_ff;
   logic [7:0]             rsp_char_in;
   logic                   rsp_inside_ff;
   logic                   rsp_inside_in;

   logic [PW+DW-1:0]       base_prod;
   logic signed [CW-1:0]   col_s;
   logic signed [CW-1:0]   row_s;
   logic                   on_hedge;
   logic                   on_vedge;
   logic                   is_get;

   assign base_prod = {{DW{1'b0}}, row_ff} * {{PW{1'b0}}, cur_ff.stride};
   assign scan_addr = base_ff + AW'(col_ff);
   assign col_s     = $signed({{(CW-PW){1'b0}}, col_ff});
   assign row_s     = $signed({{(CW-PW){1'b0}}, row_ff});
   assign on_hedge  = (row_s == cur_ff.edge_t) || (row_s == cur_ff.edge_b);
   assign on_vedge  = (col_s == cur_ff.edge_l) || (col_s == cur_ff.edge_r);
   assign is_get    = (cur_ff.kind == ccd_pkg::KIND_GET);

   assign clearing = (state_ff == ccd_pkg::ST_CLEAR);

   // Single write port: the clearing pass owns it after reset, then the second scan stage.
   always_comb begin
      if (clearing) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = ccd_pkg::SPACE_CODE;
      end else begin
         mem_we    = (s2_act_ff == ccd_pkg::ACT_WRITE) ||
                     ((s2_act_ff == ccd_pkg::ACT_COND) && (rdata_ff == cur_ff.char_a));
         mem_waddr = s2_addr_ff;
         mem_wdata = s2_code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[scan_addr];
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      clr_addr_in   = clr_addr_ff;
      s2_act_in     = ccd_pkg::ACT_NONE;
      s2_addr_in    = scan_addr;
      s2_code_in    = cur_ff.char_a;
      get_char_in   = (s2_act_ff == ccd_pkg::ACT_READ) ? rdata_ff : get_char_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_char_in   = rsp_char_ff;
      rsp_inside_in = rsp_inside_ff;
      q_pop         = 1'b0;

      case (state_ff)
         ccd_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH-1)) begin
               state_in = ccd_pkg::ST_IDLE;
            end
         end
         ccd_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               col_in   = q_head.c0;
               row_in   = q_head.r0;
               state_in = q_head.empty ? ccd_pkg::ST_RESP : ccd_pkg::ST_BASE;
            end
         end
         ccd_pkg::ST_BASE: begin
            base_in  = AW'(base_prod);
            state_in = ccd_pkg::ST_SCAN;
         end
         ccd_pkg::ST_SCAN: begin
            case (cur_ff.kind)
               ccd_pkg::KIND_WRITE: begin
                  s2_act_in = ccd_pkg::ACT_WRITE;
               end
               ccd_pkg::KIND_BORDER: begin
                  if (on_hedge) begin
                     s2_act_in  = ccd_pkg::ACT_WRITE;
                     s2_code_in = cur_ff.char_b;
                  end else if (on_vedge) begin
                     s2_act_in = ccd_pkg::ACT_WRITE;
                  end
               end
               ccd_pkg::KIND_REPLACE: begin
                  s2_act_in  = ccd_pkg::ACT_COND;
                  s2_code_in = cur_ff.char_b;
               end
               ccd_pkg::KIND_GET: begin
                  s2_act_in = ccd_pkg::ACT_READ;
               end
               default: begin
                  s2_act_in = ccd_pkg::ACT_NONE;
               end
            endcase
            if (col_ff == cur_ff.c1) begin
               col_in  = cur_ff.c0;
               row_in  = row_ff + PW'(1);
               base_in = base_ff + AW'(cur_ff.stride);
               if (row_ff == cur_ff.r1) begin
                  state_in = ccd_pkg::ST_DRAIN;
               end
            end else begin
               col_in = col_ff + PW'(1);
            end
         end
         ccd_pkg::ST_DRAIN: begin
            // The last cell finishes in the second stage during this cycle.
            state_in = ccd_pkg::ST_RESP;
         end
         ccd_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = is_get && !cur_ff.empty;
               if (is_get) begin
                  rsp_char_in = cur_ff.empty ? cur_ff.char_a : get_char_ff;
               end else begin
                  rsp_char_in = '0;
               end
               state_in = ccd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ccd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccd_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         s2_act_ff    <= ccd_pkg::ACT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         s2_act_ff    <= s2_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      base_ff       <= base_in;
      s2_addr_ff    <= s2_addr_in;
      s2_code_ff    <= s2_code_in;
      get_char_ff   <= get_char_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_inside_ff;

endmodule

// ===== src/char_cell_draw_engine.sv =====
// Top level of the character-cell draw engine: configuration registers and wiring.
// Depends on ccd_pkg, ccd_front, ccd_queue and ccd_back.
//
//  Channel  Direction  Handshake          Contents
//  req_     in         tvalid / tready    drawing command item
//  rsp_     out        tvalid / tready    one result item per command
//  csr_     in         we (no wait)       surface_width (index 0), surface_height (index 1)
//
// After reset the store is swept to spaces, one cell per clock, over all
// MAX_WIDTH * MAX_HEIGHT cells (2048 at the defaults); req_tready stays low meanwhile.
// A command is popped into the working register, its row base is formed, each cell of its
// clipped bounding box is scanned in turn through the single write port of the cell store,
// the pipe drains and the result is registered; commands that draw nothing skip the scan.
// The two-entry queue keeps taking items while the back end scans, and the result
// register holds a result while rsp_ stalls.
module char_cell_draw_engine #(
   parameter int MAX_WIDTH  = ccd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ccd_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [7:0] pos_x, [15:8] pos_y, [22:16] rect_width, [29:23] rect_height,
   // [37:30] char_a, [45:38] char_b, [47:46] zero
   input  logic [47:0]                   req_tdata,
   // [2:0] cmd
   input  logic [ccd_pkg::CMD_W-1:0]     req_tuser,

   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] read_char
   output logic [7:0]                    rsp_tdata,
   // [0] inside_res
   output logic [0:0]                    rsp_tuser,

   input  logic                          csr_we,
   input  logic [ccd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ccd_pkg::CSR_W-1:0]     csr_wdata
);

   logic [6:0]             surface_width_ff;
   logic [5:0]             surface_height_ff;
   logic                   queue_full;
   logic                   queue_valid;
   logic                   queue_pop;
   logic                   push;
   logic                   clearing;
   ccd_pkg::cmd_entry_type push_entry;
   ccd_pkg::cmd_entry_type queue_head;

   // Configuration registers. The user must make writes only while the engine is idle, so the
   // front end can classify against the current surface size; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         surface_width_ff  <= ccd_pkg::SURFACE_WIDTH_RST;
         surface_height_ff <= ccd_pkg::SURFACE_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            ccd_pkg::CSR_SURFACE_WIDTH: begin
               surface_width_ff <= csr_wdata;
            end
            ccd_pkg::CSR_SURFACE_HEIGHT: begin
               surface_height_ff <= csr_wdata[5:0];
            end
            default: begin
               surface_width_ff <= surface_width_ff;
            end
         endcase
      end
   end

   // The front end clips each command to the surface and turns it into a
   // scan window plus the edges that a border needs.
   ccd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .surface_width  (surface_width_ff),
      .surface_height (surface_height_ff),
      .queue_full     (queue_full),
      .clearing       (clearing),
      .push           (push),
      .push_entry     (push_entry)
   );

   ccd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .not_empty  (queue_valid),
      .head       (queue_head),
      .pop        (queue_pop)
   );

   // The back end walks the window row by row, one cell per clock, through a
   // two-stage read/modify/write pipe on the cell store.
   ccd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (queue_valid),
      .q_head     (queue_head),
      .q_pop      (queue_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== src/ccd_checker.sv =====
// Port-level checker for the character-cell draw engine, bound to the top level.
// Depends on ccd_pkg and char_cell_draw_engine.
module ccd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser
);

   logic [3:0] pending_ff;
   logic [3:0] pending_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 4'd1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // The store is being cleared right after reset, so no item may be taken.
   a_no_take_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during the clearing pass");

   // Every result belongs to an item that was taken and not yet answered.
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != 4'd0))
      else $error("result without an outstanding item");

   // Queue, working register and result register bound the items in flight.
   a_in_flight_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'(ccd_pkg::MAX_OUTSTANDING))
      else $error("more items in flight than the engine can hold");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind char_cell_draw_engine ccd_checker u_ccd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
